[hw/rtl/qba_pkg.sv]
package qba_pkg;

  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // components wider than this are prescaled so that every product stays narrow
  localparam int unsigned EFF_WIDTH_MAX  = 30;

endpackage

[hw/rtl/qba_if.sv]
interface qba_in_if #(
  parameter int unsigned COMP_WIDTH = qba_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] quat_w;
  logic signed [COMP_WIDTH-1:0] quat_x;
  logic signed [COMP_WIDTH-1:0] quat_y;
  logic signed [COMP_WIDTH-1:0] quat_z;
  logic                         torso;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, torso, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, torso, output ready);
endinterface

interface qba_out_if #(
  parameter int unsigned COMP_WIDTH = qba_pkg::COMP_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         axis_valid;
  logic signed [COMP_WIDTH-1:0] axis_x;
  logic signed [COMP_WIDTH-1:0] axis_y;
  logic signed [COMP_WIDTH-1:0] axis_z;

  modport source (output valid, axis_valid, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, axis_valid, axis_x, axis_y, axis_z, output ready);
endinterface

[hw/rtl/quaternion_basis_axis_unit.sv]
// Rotates +Z (limb) or +X negated (torso) by a Q1.14 quaternion and returns the unit
// axis in the same format, rounded half away from zero. Takes one quaternion every
// cycle unless the output stalls; four arithmetic stages come first, then a divider
// that resolves one quotient bit per stage and a rounding stage. A zero-norm
// quaternion returns axis_valid=0 with a zero axis. The whole pipe stalls while the
// output beat is not taken.
module quaternion_basis_axis_unit #(
  parameter int unsigned COMP_WIDTH = qba_pkg::COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qba_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qba_in_if.sink     in_if,
  qba_out_if.source  out_if
);

  localparam int unsigned EW  = (COMP_WIDTH > qba_pkg::EFF_WIDTH_MAX) ?
                                qba_pkg::EFF_WIDTH_MAX : COMP_WIDTH;
  localparam int unsigned PS  = COMP_WIDTH - EW;
  localparam int unsigned PW  = 2 * EW;
  localparam int unsigned NW  = PW + 1;
  localparam int unsigned CW2 = PW + 3;
  localparam int unsigned D   = FRAC_BITS + 6;

  logic en;
  logic v_q  [0:D-1];
  logic nz_q [2:D-1];

  assign en          = !v_q[D-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) v_q[i] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_if.valid;
      for (int i = 1; i < D; i++) v_q[i] <= v_q[i-1];
    end
  end

  // stage 0: prescale wide components, truncating toward zero
  logic signed [EW-1:0] w_q, x_q, y_q, z_q;
  logic                 t_q [0:2];

  function automatic logic signed [EW-1:0] prescale(input logic signed [COMP_WIDTH-1:0] v);
    logic signed [COMP_WIDTH:0] t;
    t = $signed({v[COMP_WIDTH-1], v}) +
        (v[COMP_WIDTH-1] ? (COMP_WIDTH+1)'((1 << PS) - 1) : '0);
    return EW'(t >>> PS);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q    <= prescale(in_if.quat_w);
      x_q    <= prescale(in_if.quat_x);
      y_q    <= prescale(in_if.quat_y);
      z_q    <= prescale(in_if.quat_z);
      t_q[0] <= in_if.torso;
    end
  end

  // stage 1: products
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q   <= w_q * w_q;
      xx_q   <= x_q * x_q;
      yy_q   <= y_q * y_q;
      zz_q   <= z_q * z_q;
      xy_q   <= x_q * y_q;
      wz_q   <= w_q * z_q;
      xz_q   <= x_q * z_q;
      wy_q   <= w_q * y_q;
      yz_q   <= y_q * z_q;
      wx_q   <= w_q * x_q;
      t_q[1] <= t_q[0];
    end
  end

  // stage 2: norm and unsigned-sign rotated components (torso negation applied later)
  logic signed [CW2-1:0] n2_q, c0_q, c1_q, c2_q;
  logic signed [CW2-1:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
  logic signed [CW2-1:0] n_d, c0_d, c1_d, c2_d;

  always_comb begin
    e_ww = CW2'(ww_q);
    e_xx = CW2'(xx_q);
    e_yy = CW2'(yy_q);
    e_zz = CW2'(zz_q);
    e_xy = CW2'(xy_q);
    e_wz = CW2'(wz_q);
    e_xz = CW2'(xz_q);
    e_wy = CW2'(wy_q);
    e_yz = CW2'(yz_q);
    e_wx = CW2'(wx_q);
    n_d  = e_ww + e_xx + e_yy + e_zz;
    if (t_q[1]) begin
      c0_d = e_ww + e_xx - e_yy - e_zz;
      c1_d = (e_xy + e_wz) <<< 1;
      c2_d = (e_xz - e_wy) <<< 1;
    end else begin
      c0_d = (e_xz + e_wy) <<< 1;
      c1_d = (e_yz - e_wx) <<< 1;
      c2_d = e_ww - e_xx - e_yy + e_zz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q    <= n_d;
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
      t_q[2]  <= t_q[1];
      nz_q[2] <= (n_d != '0);
      for (int i = 3; i < D; i++) nz_q[i] <= nz_q[i-1];
    end
  end

  // stage 3: magnitude and sign
  logic [NW-1:0] n3_q, a0_q, a1_q, a2_q;
  logic          g0_q, g1_q, g2_q;

  function automatic logic [NW-1:0] mag(input logic signed [CW2-1:0] c);
    logic signed [CW2-1:0] m;
    m = c[CW2-1] ? -c : c;
    return m[NW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q <= n2_q[NW-1:0];
      a0_q <= mag(c0_q);
      a1_q <= mag(c1_q);
      a2_q <= mag(c2_q);
      g0_q <= c0_q[CW2-1] ^ t_q[2];
      g1_q <= c1_q[CW2-1] ^ t_q[2];
      g2_q <= c2_q[CW2-1] ^ t_q[2];
    end
  end

  logic signed [COMP_WIDTH-1:0] qx, qy, qz;

  qba_div_pipe #(.NW(NW), .FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_div_x (
    .clk_i, .en_i(en), .a_i(a0_q), .n_i(n3_q), .neg_i(g0_q), .q_o(qx)
  );
  qba_div_pipe #(.NW(NW), .FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_div_y (
    .clk_i, .en_i(en), .a_i(a1_q), .n_i(n3_q), .neg_i(g1_q), .q_o(qy)
  );
  qba_div_pipe #(.NW(NW), .FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_div_z (
    .clk_i, .en_i(en), .a_i(a2_q), .n_i(n3_q), .neg_i(g2_q), .q_o(qz)
  );

  assign out_if.valid      = v_q[D-1];
  assign out_if.axis_valid = nz_q[D-1];
  assign out_if.axis_x     = nz_q[D-1] ? qx : '0;
  assign out_if.axis_y     = nz_q[D-1] ? qy : '0;
  assign out_if.axis_z     = nz_q[D-1] ? qz : '0;

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready does not track output stall");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.axis_valid |->
      out_if.axis_x == '0 && out_if.axis_y == '0 && out_if.axis_z == '0)
    else $error("zero-norm beat carries a nonzero axis");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.axis_valid |->
      out_if.axis_x != '0 || out_if.axis_y != '0 || out_if.axis_z != '0)
    else $error("valid axis is all zero");

endmodule

[hw/rtl/qba_div_pipe.sv]
// Pipelined restoring divider: round(a * 2^FRAC_BITS / n), one quotient bit per stage,
// then rounding, sign and saturation.
module qba_div_pipe #(
  parameter int unsigned NW         = 31,
  parameter int unsigned FRAC_BITS  = qba_pkg::FRAC_BITS_DEF,
  parameter int unsigned COMP_WIDTH = qba_pkg::COMP_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [NW-1:0]                a_i,
  input  logic [NW-1:0]                n_i,
  input  logic                         neg_i,
  output logic signed [COMP_WIDTH-1:0] q_o
);

  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned SW = (QW + 1 > COMP_WIDTH + 1) ? QW + 1 : COMP_WIDTH + 1;

  logic [NW-1:0] r_q   [0:FRAC_BITS];
  logic [NW-1:0] n_q   [0:FRAC_BITS];
  logic [QW-1:0] qq_q  [0:FRAC_BITS];
  logic          neg_q [0:FRAC_BITS];

  // integer part: |c| <= n, so at most one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (a_i >= n_i) begin
        r_q[0]  <= a_i - n_i;
        qq_q[0] <= QW'(1);
      end else begin
        r_q[0]  <= a_i;
        qq_q[0] <= '0;
      end
      n_q[0]   <= n_i;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [NW:0] r2;
    logic [NW:0] n2;
    logic        ge;

    assign r2 = {r_q[k-1], 1'b0};
    assign n2 = {1'b0, n_q[k-1]};
    assign ge = (r2 >= n2);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? NW'(r2 - n2) : NW'(r2);
        qq_q[k]  <= {qq_q[k-1][QW-2:0], ge};
        n_q[k]   <= n_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [QW-1:0]        q_rnd;
  logic [SW-1:0]        q_ext;
  logic signed [SW-1:0] s_val;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] s_sat;

  always_comb begin
    q_rnd = qq_q[FRAC_BITS] +
            QW'({r_q[FRAC_BITS], 1'b0} >= {1'b0, n_q[FRAC_BITS]});
    q_ext = SW'(q_rnd);
    s_val = neg_q[FRAC_BITS] ? -$signed(q_ext) : $signed(q_ext);
    hi    = $signed({{(SW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}});
    lo    = ~hi;
    if (s_val > hi) begin
      s_sat = hi;
    end else if (s_val < lo) begin
      s_sat = lo;
    end else begin
      s_sat = s_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= s_sat[COMP_WIDTH-1:0];
    end
  end

endmodule

[dv/quaternion_basis_axis_unit_tb.sv]
module quaternion_basis_axis_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = qba_pkg::COMP_WIDTH_DEF;
  localparam int unsigned FB = qba_pkg::FRAC_BITS_DEF;
  localparam int unsigned LATENCY = FB + 6;
  localparam int unsigned N_RANDOM = 530;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
    logic  torso;
  } quat_beat_t;

  typedef struct packed {
    logic  ok;
    comp_t ax;
    comp_t ay;
    comp_t az;
  } axis_beat_t;

  typedef struct packed {
    quat_beat_t q;
    logic       known;
    axis_beat_t a;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   n_errors = 0;
  bit   stim_done = 1'b0;

  qba_in_if  #(.COMP_WIDTH(CW)) in_if ();
  qba_out_if #(.COMP_WIDTH(CW)) out_if ();

  quaternion_basis_axis_unit #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("quaternion_basis_axis_unit_tb NOT OK");
    $finish;
  end

  axis_beat_t axis_q[$];

  // round(c * 2^FB / n) half away from zero, saturated
  function automatic comp_t div_round(longint c, longint unsigned n);
    longint unsigned a;
    longint unsigned q;
    longint unsigned r;
    longint s;
    longint hi;
    a = (c < 0) ? longint'(-c) : c;
    q = 0;
    r = a;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    if (r >= n) begin
      q = 1;
      r -= n;
    end
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= n) begin
        r -= n;
        q |= 1;
      end
    end
    if ((r << 1) >= n) q += 1;
    s = (c < 0) ? -longint'(q) : longint'(q);
    if (s > hi) s = hi;
    if (s < -hi - 1) s = -hi - 1;
    return comp_t'(s);
  endfunction

  function automatic axis_beat_t predict_axis(quat_beat_t b);
    axis_beat_t r;
    longint w, x, y, z, ww, xx, yy, zz, vx, vy, vz;
    longint unsigned n;
    w = b.w; x = b.x; y = b.y; z = b.z;
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n = ww + xx + yy + zz;
    r = '0;
    if (n == 0) return r;
    if (b.torso) begin
      vx = -(ww + xx - yy - zz);
      vy = -(2 * (x * y + w * z));
      vz = -(2 * (x * z - w * y));
    end else begin
      vx = 2 * (x * z + w * y);
      vy = 2 * (y * z - w * x);
      vz = ww - xx - yy + zz;
    end
    r.ok = 1'b1;
    r.ax = div_round(vx, n);
    r.ay = div_round(vy, n);
    r.az = div_round(vz, n);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic comp_t rand_comp();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return comp_t'(16'sh8000);
      1: return comp_t'(16'sh7fff);
      2: return comp_t'(0);
      3: return comp_t'($signed($urandom_range(0, 15)) - 8);
      default: return comp_t'($urandom);
    endcase
  endfunction

  localparam comp_t ONE = comp_t'(1 << FB);
  localparam comp_t MAXP = comp_t'(16'sh7fff);
  localparam comp_t MINN = comp_t'(16'sh8000);

  vec_row_t vectors[] = '{
    '{'{0, 0, 0, 0, 1'b0}, 1'b1, '{1'b0, 0, 0, 0}},
    '{'{0, 0, 0, 0, 1'b1}, 1'b1, '{1'b0, 0, 0, 0}},
    '{'{ONE, 0, 0, 0, 1'b0}, 1'b1, '{1'b1, 0, 0, ONE}},
    '{'{ONE, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, -ONE, 0, 0}},
    '{'{MAXP, 0, 0, 0, 1'b0}, 1'b1, '{1'b1, 0, 0, ONE}},
    '{'{MINN, 0, 0, 0, 1'b1}, 1'b1, '{1'b1, -ONE, 0, 0}},
    '{'{0, ONE, 0, 0, 1'b0}, 1'b1, '{1'b1, 0, 0, -ONE}},
    '{'{0, 0, 0, MINN, 1'b0}, 1'b1, '{1'b1, 0, 0, ONE}},
    '{'{MINN, MINN, MINN, MINN, 1'b0}, 1'b0, '0},
    '{'{MAXP, MAXP, MAXP, MAXP, 1'b1}, 1'b0, '0},
    '{'{MAXP, MINN, MAXP, MINN, 1'b0}, 1'b0, '0},
    '{'{1, 0, 0, 0, 1'b0}, 1'b1, '{1'b1, 0, 0, ONE}},
    '{'{0, 0, -1, 0, 1'b1}, 1'b1, '{1'b1, ONE, 0, 0}},
    '{'{1, 1, 1, 1, 1'b0}, 1'b0, '0},
    '{'{-1, 1, -1, 1, 1'b1}, 1'b0, '0},
    '{'{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 1'b0}, 1'b0, '0},
    '{'{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 1'b1}, 1'b0, '0},
    '{'{0, MAXP, 1, 0, 1'b1}, 1'b0, '0}
  };

  // valid stays high after a beat is taken; it drops only for a gap
  task automatic send_beat(quat_beat_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.quat_w <= b.w;
    in_if.quat_x <= b.x;
    in_if.quat_y <= b.y;
    in_if.quat_z <= b.z;
    in_if.torso  <= b.torso;
    do @(posedge clk_i); while (!in_if.ready);
    axis_q.insert(axis_q.size(), predict_axis(b));
  endtask

  // sink side: random back-pressure, compare each beat with the oldest expectation
  initial begin
    axis_beat_t e;
    int hold;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (axis_q.size() == 0) begin
          $display("%0t: unexpected axis beat %b %0d %0d %0d", $realtime, out_if.axis_valid,
                   out_if.axis_x, out_if.axis_y, out_if.axis_z);
          n_errors++;
        end else begin
          e = axis_q[0];
          axis_q.delete(0);
          if (out_if.axis_valid !== e.ok || out_if.axis_x !== e.ax ||
              out_if.axis_y !== e.ay || out_if.axis_z !== e.az) begin
            $display("%0t: mismatch exp %b %0d %0d %0d act %b %0d %0d %0d", $realtime,
                     e.ok, e.ax, e.ay, e.az, out_if.axis_valid, out_if.axis_x,
                     out_if.axis_y, out_if.axis_z);
            n_errors++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        hold = gap_len();
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    quat_beat_t b;
    axis_beat_t got;
    in_if.valid  = 1'b0;
    in_if.quat_w = '0;
    in_if.quat_x = '0;
    in_if.quat_y = '0;
    in_if.quat_z = '0;
    in_if.torso  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vectors[i]) begin
      if (vectors[i].known) begin
        got = predict_axis(vectors[i].q);
        if (got !== vectors[i].a) begin
          $display("%0t: predictor row %0d exp %p act %p", $realtime, i, vectors[i].a, got);
          n_errors++;
        end
      end
      send_beat(vectors[i].q);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // drain the pipe once before continuing
        in_if.valid <= 1'b0;
        while (axis_q.size() != 0) @(posedge clk_i);
      end
      b.w = rand_comp();
      b.x = rand_comp();
      b.y = rand_comp();
      b.z = rand_comp();
      b.torso = 1'($urandom_range(0, 1));
      send_beat(b);
    end
    in_if.valid <= 1'b0;
    while (axis_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0 && axis_q.size() == 0) begin
      $display("quaternion_basis_axis_unit_tb OK");
    end else begin
      $display("quaternion_basis_axis_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
